// ===== rtl/gmsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsh_pkg: shared types and constants
// Register indexes, thresholds and the command struct to the divider.
// ----------------------------------------------------------------------------
package gmsh_pkg;
	localparam int CHANNELS_DEF = 4;
	localparam int REG_COUNT = 8;
	localparam logic [2:0] REG_LCX = 3'd0;
	localparam logic [2:0] REG_LCY = 3'd1;
	localparam logic [2:0] REG_LSX = 3'd2;
	localparam logic [2:0] REG_LSY = 3'd3;
	localparam logic [2:0] REG_RCX = 3'd4;
	localparam logic [2:0] REG_RCY = 3'd5;
	localparam logic [2:0] REG_RSX = 3'd6;
	localparam logic [2:0] REG_RSY = 3'd7;
	localparam logic signed [8:0] SET_TH = 9'sd30;
	localparam logic signed [8:0] HOLD_TH = 9'sd20;
	localparam logic signed [7:0] FULL_V = 8'sd127;
	localparam logic signed [7:0] DIAG_V = 8'sd89;
	localparam logic [1:0] EXT_NUN = 2'd1;
	localparam logic [1:0] EXT_CLS = 2'd2;

	typedef struct packed {
		logic       start;
		logic [7:0] pos;
		logic [7:0] center;
		logic [7:0] span;
	} div_cmd_t;
endpackage

// ===== rtl/gmsh_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsh_norm: shared stick normalizer
// Computes (pos-center)*127/span truncated toward zero and saturated,
// with a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmsh_norm
	import gmsh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_cmd_t          cmd,
	output logic              done,
	output logic signed [7:0] result
);
	// |d|*127 fits in 15 bits.
	logic [14:0] rem_q;
	logic [14:0] quo_q;
	logic [7:0]  span_q;
	logic        neg_q;
	logic        busy_q;
	logic [3:0]  cnt_q;
	logic        zero_q;

	logic signed [8:0] diff;
	logic [8:0]  mag;
	logic [15:0] prod;

	assign diff = $signed({1'b0, cmd.pos}) - $signed({1'b0, cmd.center});
	assign mag = diff[8] ? 9'(-diff) : 9'(diff);
	assign prod = 16'(mag) * 16'd127;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 4'd14) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	// Simple restoring division: remainder register r, dividend bits shift in.
	logic [7:0]  r_q;
	logic [15:0] sub;
	assign sub = {r_q, rem_q[14 - cnt_q]} - {8'd0, span_q};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= prod[14:0];
			span_q <= cmd.span;
			neg_q <= diff[8];
			zero_q <= (cmd.span == 8'd0);
			quo_q <= '0;
			r_q <= '0;
		end else if (busy_q) begin
			if (!sub[15] && ({r_q, 1'b0} | 9'(rem_q[14 - cnt_q])) >= 9'(span_q)) begin
				r_q <= sub[7:0];
				quo_q <= {quo_q[13:0], 1'b1};
			end else begin
				r_q <= {r_q[6:0], rem_q[14 - cnt_q]};
				quo_q <= {quo_q[13:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) begin
			result = 8'sd0;
		end else if (neg_q) begin
			result = (quo_q > 15'd128) ? -8'sd128 : 8'(-quo_q);
		end else begin
			result = (quo_q > 15'd127) ? 8'sd127 : 8'(quo_q);
		end
	end
endmodule

// ===== rtl/gamepad_merge_with_stick_hysteresis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_merge_with_stick_hysteresis: controller snapshot merger
// Merges pad, remote and extension inputs into one held mask with
// stick-to-d-pad hysteresis and returns held, pressed, released and sticks.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | channel, buttons, sticks, extension
//  out     | out_valid/out_ready | out_channel, masks, final sticks
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// Up to four normalizations run one after another through the shared
// bit-serial divider (each a launch state, the divide and a wait for its
// done strobe), then a merge state writes the result. A classic
// request needs four normalizations, a nunchuk request two, and requests
// without an extension skip the divider. Reset clears the held store and
// the handshake state and loads the config registers with their defaults.
// The block takes no request until its result register is free.
module gamepad_merge_with_stick_hysteresis
	import gmsh_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        channel,
	input  logic [12:0]       pad_buttons,
	input  logic signed [7:0] pad_stick_x,
	input  logic signed [7:0] pad_stick_y,
	input  logic signed [7:0] pad_cstick_x,
	input  logic signed [7:0] pad_cstick_y,
	input  logic [13:0]       remote_buttons,
	input  logic [1:0]        ext_type,
	input  logic [7:0]        ext_left_x,
	input  logic [7:0]        ext_left_y,
	input  logic [7:0]        ext_right_x,
	input  logic [7:0]        ext_right_y,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_channel,
	output logic [12:0]       held_mask,
	output logic [12:0]       pressed_mask,
	output logic [12:0]       released_mask,
	output logic signed [7:0] stick_x,
	output logic signed [7:0] stick_y,
	output logic signed [7:0] cstick_x,
	output logic signed [7:0] cstick_y,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data
);
	localparam int SW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LAUNCH = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_MERGE = 3'd3;

	logic [2:0] state_q;
	logic [1:0] job_q;
	logic [7:0] regs_q [REG_COUNT];
	logic [12:0] held_store_q [CHANNELS];

	// Captured request.
	logic [1:0]        ch_q;
	logic [12:0]       pb_q;
	logic signed [7:0] sx_q, sy_q, cx_q, cy_q;
	logic [13:0]       rb_q;
	logic [1:0]        et_q;
	logic [7:0]        lx_q, ly_q, rx_q, ry_q;
	logic signed [7:0] n_q [4];

	div_cmd_t          cmd;
	logic              ndone;
	logic signed [7:0] nres;

	gmsh_norm u_norm (.clk(clk), .arst_n(arst_n), .cmd(cmd), .done(ndone), .result(nres));

	logic nun, cls, need_ext, need_right;
	assign nun = (et_q == EXT_NUN);
	assign cls = (et_q == EXT_CLS);
	assign need_ext = nun || cls;
	assign need_right = cls && !(nun && rb_q[7]);

	always_comb begin
		cmd.start = (state_q == ST_LAUNCH);
		case (job_q)
			2'd0: begin
				cmd.pos = lx_q; cmd.center = regs_q[REG_LCX]; cmd.span = regs_q[REG_LSX];
			end
			2'd1: begin
				cmd.pos = ly_q; cmd.center = regs_q[REG_LCY]; cmd.span = regs_q[REG_LSY];
			end
			2'd2: begin
				cmd.pos = rx_q; cmd.center = regs_q[REG_RCX]; cmd.span = regs_q[REG_RSX];
			end
			default: begin
				cmd.pos = ry_q; cmd.center = regs_q[REG_RCY]; cmd.span = regs_q[REG_RSY];
			end
		endcase
	end

	// Slot for the held store; out-of-range channels share slot 0.
	logic [SW-1:0] slot;
	always_comb begin
		if (32'(ch_q) < CHANNELS) slot = SW'(ch_q);
		else slot = '0;
	end

	function automatic logic [3:0] dirs(input logic signed [7:0] x,
		input logic signed [7:0] y, input logic [12:0] p);
		logic [3:0] r;
		r = '0;
		r[1] = (9'(x) > SET_TH) || (p[1] && 9'(x) > HOLD_TH);
		r[0] = (9'(x) < -SET_TH) || (p[0] && 9'(x) < -HOLD_TH);
		r[3] = (9'(y) > SET_TH) || (p[3] && 9'(y) > HOLD_TH);
		r[2] = (9'(y) < -SET_TH) || (p[2] && 9'(y) < -HOLD_TH);
		return r;
	endfunction

	// Direction flags to a secondary stick override: {valid_x,valid_y,x,y}.
	function automatic logic [17:0] to_c(input logic rt, input logic lf,
		input logic up, input logic dn);
		logic signed [7:0] tx, ty;
		tx = 8'sd0;
		ty = 8'sd0;
		if (rt) tx = FULL_V;
		else if (lf) tx = -FULL_V;
		if (up) ty = FULL_V;
		else if (dn) ty = -FULL_V;
		if (tx != 0 && ty != 0) begin
			tx = (tx > 0) ? DIAG_V : -DIAG_V;
			ty = (ty > 0) ? DIAG_V : -DIAG_V;
		end
		return {tx != 0, ty != 0, tx, ty};
	endfunction

	logic [12:0] prev, held, h2;
	logic signed [7:0] fsx, fsy, fcx, fcy, wsx, wsy;
	logic use_ext;
	logic [17:0] ov;
	logic [3:0] dd;

	always_comb begin
		prev = held_store_q[slot];
		use_ext = !(nun && rb_q[7]);
		wsx = need_ext ? n_q[0] : 8'sd0;
		wsy = need_ext ? n_q[1] : 8'sd0;
		held = pb_q;
		fsx = sx_q; fsy = sy_q; fcx = cx_q; fcy = cy_q;
		if (cls) begin
			held[1] = held[1] | rb_q[8];
			held[0] = held[0] | rb_q[9];
			held[3] = held[3] | rb_q[10];
			held[2] = held[2] | rb_q[11];
			held[8] = held[8] | rb_q[12];
			held[9] = held[9] | rb_q[13];
		end
		held[3:0] = held[3:0] | dirs(sx_q, sy_q, prev);
		if (use_ext) held[3:0] = held[3:0] | dirs(wsx, wsy, prev);
		if (!rb_q[5]) begin
			held[1] = held[1] | rb_q[0];
			held[0] = held[0] | rb_q[1];
			held[3] = held[3] | rb_q[2];
			held[2] = held[2] | rb_q[3];
			held[8] = held[8] | rb_q[4];
			held[9] = held[9] | rb_q[6];
		end
		if (use_ext) begin
			if (wsx != 0) fsx = wsx;
			if (wsy != 0) fsy = wsy;
		end
		ov = '0;
		if (nun && rb_q[7]) begin
			if (wsx != 0) fcx = wsx;
			if (wsy != 0) fcy = wsy;
		end else if (cls) begin
			if (n_q[2] != 0) fcx = n_q[2];
			if (n_q[3] != 0) fcy = n_q[3];
		end else if (rb_q[5]) begin
			ov = to_c(rb_q[0], rb_q[1], rb_q[2], rb_q[3]);
			if (ov[17]) fcx = ov[15:8];
			if (ov[16]) fcy = ov[7:0];
		end
		dd = held[3:0];
		h2 = held;
		if (held[4]) begin
			ov = to_c(dd[1], dd[0], dd[3], dd[2]);
			if (ov[17]) fcx = ov[15:8];
			if (ov[16]) fcy = ov[7:0];
			h2[3:0] = 4'd0;
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= '0;
			out_valid <= 1'b0;
			regs_q[REG_LCX] <= 8'd128; regs_q[REG_LCY] <= 8'd128;
			regs_q[REG_LSX] <= 8'd100; regs_q[REG_LSY] <= 8'd100;
			regs_q[REG_RCX] <= 8'd128; regs_q[REG_RCY] <= 8'd128;
			regs_q[REG_RSX] <= 8'd100; regs_q[REG_RSY] <= 8'd100;
			for (int i = 0; i < CHANNELS; i++) held_store_q[i] <= '0;
		end else begin
			if (cfg_we) regs_q[cfg_index] <= cfg_data;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						job_q <= '0;
						state_q <= (ext_type == EXT_NUN || ext_type == EXT_CLS)
							? ST_LAUNCH : ST_MERGE;
					end
				end
				ST_LAUNCH: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (ndone) begin
						if (job_q == 2'd3 || (job_q == 2'd1 && !need_right)) begin
							state_q <= ST_MERGE;
						end else begin
							job_q <= job_q + 2'd1;
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_MERGE: begin
					held_store_q[slot] <= h2;
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_q <= channel; pb_q <= pad_buttons;
			sx_q <= pad_stick_x; sy_q <= pad_stick_y;
			cx_q <= pad_cstick_x; cy_q <= pad_cstick_y;
			rb_q <= remote_buttons; et_q <= ext_type;
			lx_q <= ext_left_x; ly_q <= ext_left_y;
			rx_q <= ext_right_x; ry_q <= ext_right_y;
			n_q[2] <= 8'sd0; n_q[3] <= 8'sd0;
		end
		if (state_q == ST_WAIT && ndone) n_q[job_q] <= nres;
		if (state_q == ST_MERGE) begin
			out_channel <= ch_q;
			held_mask <= h2;
			pressed_mask <= h2 & ~prev;
			released_mask <= ~h2 & prev;
			stick_x <= fsx; stick_y <= fsy;
			cstick_x <= fcx; cstick_y <= fcy;
		end
	end
endmodule

// ===== rtl/gmsh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsh_checker: port-level checks
// Watches the handshakes and result consistency of the top level.
// ----------------------------------------------------------------------------
module gmsh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [12:0] held_mask,
	input logic [12:0] pressed_mask,
	input logic [12:0] released_mask
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(held_mask))
		else $error("result dropped while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");
	a_pressed_sub: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pressed_mask & ~held_mask) == 13'd0)
		else $error("pressed bit not held");
	a_released_dis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (released_mask & held_mask) == 13'd0)
		else $error("released bit still held");
endmodule

bind gamepad_merge_with_stick_hysteresis gmsh_checker u_gmsh_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .held_mask(held_mask),
	.pressed_mask(pressed_mask), .released_mask(released_mask));
